// File: rtl/core/ucud_pkg.sv
// Shared types, encoding codes and helper functions of the code unit decoder.
`timescale 1ns / 1ps
package ucud_pkg;

	typedef enum logic [2:0] {
		ENC_BYTE  = 3'd0,
		ENC_UCS2  = 3'd1,
		ENC_UCS4  = 3'd2,
		ENC_UTF8  = 3'd3,
		ENC_UTF16 = 3'd4
	} ucud_enc_t;

	localparam logic REG_ENCODING   = 1'b0;
	localparam logic REG_SWAP_BYTES = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int CpW = 31;

	typedef struct packed {
		logic [31:0] code_unit;
		logic        start_of_stream;
	} ucud_in_t;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           status;
	} ucud_out_t;

	typedef struct packed {
		logic       we;
		logic       index;
		logic [2:0] wdata;
	} ucud_cfg_wr_t;

	typedef struct packed {
		logic      vld;
		ucud_out_t data;
	} ucud_res_t;

	// Smallest value that needs a UTF-8 sequence of the given length.
	function automatic logic [CpW-1:0] utf8_min_value(input logic [2:0] len);
		logic [CpW-1:0] v;
		case (len)
			3'd2:    v = CpW'(32'h0000_0080);
			3'd3:    v = CpW'(32'h0000_0800);
			3'd4:    v = CpW'(32'h0001_0000);
			3'd5:    v = CpW'(32'h0020_0000);
			3'd6,
			3'd7:    v = CpW'(32'h0400_0000);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] u);
		return {u[7:0], u[15:8], u[23:16], u[31:24]};
	endfunction

endpackage

// File: rtl/core/unicode_code_unit_decoder.sv
// Top level of the code unit decoder: input register, decode logic, result register.
// Decodes one code unit per cycle as byte, UCS-2, UCS-4, UTF-8 or UTF-16 (set by the
// encoding register, with optional byte swap of 16- and 32-bit units) and gives at most
// one code point per unit; a multi-unit character gives its result on its last unit.
// A unit is taken every cycle while results are taken; a result is shown after its unit
// passes the input register and the combinational decode into the result register, which
// loads only while it is empty or its result is taken. After a decoding error (or with an
// unused encoding code) one error result (code point zero) is given and units are
// dropped without result until a unit with start_of_stream set. Write configuration only
// while no unit is in flight.
`timescale 1ns / 1ps
module unicode_code_unit_decoder import ucud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ucud_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output ucud_out_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [2:0] cfg_wdata
);

	logic         valid_s1;
	ucud_in_t     data_s1;
	logic         can_take;
	logic         advance;
	ucud_res_t    res;
	ucud_cfg_wr_t cfg;

	assign advance   = valid_s1 && can_take;
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	ucud_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	ucud_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.advance  (advance),
		.res      (res)
	);

	ucud_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.advance   (advance),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/core/ucud_in_stage.sv
// Input register stage of the code unit decoder.
`timescale 1ns / 1ps
module ucud_in_stage import ucud_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ucud_in_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output ucud_in_t data_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

// File: rtl/core/ucud_decode.sv
// Decode logic with configuration and stream state of the code unit decoder.
`timescale 1ns / 1ps
module ucud_decode import ucud_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  ucud_cfg_wr_t cfg,
	input  logic         valid_s1,
	input  ucud_in_t     data_s1,
	input  logic         advance,
	output ucud_res_t    res
);

	logic [2:0]     enc_q;
	logic           swap_q;
	logic [CpW-1:0] acc_q;
	logic [2:0]     rem_q;
	logic [2:0]     len_q;
	logic [10:0]    hs_off_q;
	logic           pend_q;
	logic           stop_q;

	logic [CpW-1:0] acc_n;
	logic [2:0]     rem_n;
	logic [2:0]     len_n;
	logic [10:0]    hs_off_n;
	logic           pend_n;
	logic           stop_n;

	logic [31:0]    unit;
	logic [31:0]    unit_sw;
	logic [7:0]     b;
	logic [15:0]    u16;
	logic [2:0]     rem_dec;
	logic [CpW-1:0] acc_shift;
	logic [21:0]    pair_value;
	logic           emit;
	logic           err;
	logic [CpW-1:0] cp;

	assign unit      = data_s1.code_unit;
	assign unit_sw   = swap32(unit);
	assign b         = unit[7:0];
	assign u16       = swap_q ? {unit[7:0], unit[15:8]} : unit[15:0];
	assign rem_dec   = rem_q - 3'd1;
	assign acc_shift = {acc_q[CpW-7:0], b[5:0]};
	// ((hs - D800) << 10) + u - DC00 + 10000 folds to offset << 10 + u + 2400
	assign pair_value = {hs_off_q, 10'd0} + 22'(u16) + 22'h2400;

	always_comb begin
		acc_n    = acc_q;
		rem_n    = rem_q;
		len_n    = len_q;
		hs_off_n = hs_off_q;
		pend_n   = pend_q;
		stop_n   = stop_q;
		emit     = 1'b0;
		err      = 1'b0;
		cp       = '0;

		if (data_s1.start_of_stream) begin
			acc_n    = '0;
			rem_n    = '0;
			len_n    = '0;
			hs_off_n = '0;
			pend_n   = 1'b0;
			stop_n   = 1'b0;
		end

		if (!stop_n) begin
			case (enc_q)
				ENC_BYTE: begin
					emit = 1'b1;
					cp   = CpW'(b);
				end
				ENC_UCS2: begin
					emit = 1'b1;
					cp   = CpW'(u16);
				end
				ENC_UCS4: begin
					emit = 1'b1;
					cp   = swap_q ? unit_sw[CpW-1:0] : unit[CpW-1:0];
				end
				ENC_UTF8: begin
					if (rem_n == 3'd0) begin
						if (!b[7]) begin
							emit = 1'b1;
							cp   = CpW'(b);
						end else if (b[7:5] == 3'b110) begin
							acc_n = CpW'(b[4:0]);
							len_n = 3'd2;
							rem_n = 3'd1;
						end else if (b[7:4] == 4'b1110) begin
							acc_n = CpW'(b[3:0]);
							len_n = 3'd3;
							rem_n = 3'd2;
						end else if (b[7:3] == 5'b11110) begin
							acc_n = CpW'(b[2:0]);
							len_n = 3'd4;
							rem_n = 3'd3;
						end else if (b[7:2] == 6'b111110) begin
							acc_n = CpW'(b[1:0]);
							len_n = 3'd5;
							rem_n = 3'd4;
						end else if (b[7:1] == 7'b1111110) begin
							acc_n = CpW'(b[0]);
							len_n = 3'd6;
							rem_n = 3'd5;
						end else begin
							// stray continuation or FE/FF where a lead is due
							emit = 1'b1;
							err  = 1'b1;
						end
					end else if (b[7:6] != 2'b10) begin
						emit = 1'b1;
						err  = 1'b1;
					end else begin
						acc_n = acc_shift;
						rem_n = rem_dec;
						if (rem_dec == 3'd0) begin
							acc_n = '0;
							len_n = '0;
							emit  = 1'b1;
							cp    = acc_shift;
							// reject overlong forms
							err   = acc_shift < utf8_min_value(len_q);
						end
					end
				end
				ENC_UTF16: begin
					if (pend_n) begin
						emit     = 1'b1;
						cp       = CpW'(pair_value);
						pend_n   = 1'b0;
						hs_off_n = '0;
					end else if (u16[15:11] == 5'b11011) begin
						hs_off_n = u16[10:0];
						pend_n   = 1'b1;
					end else begin
						emit = 1'b1;
						cp   = CpW'(u16);
					end
				end
				default: begin
					emit = 1'b1;
					err  = 1'b1;
				end
			endcase
		end

		if (err) begin
			cp       = '0;
			stop_n   = 1'b1;
			acc_n    = '0;
			rem_n    = '0;
			len_n    = '0;
			hs_off_n = '0;
			pend_n   = 1'b0;
		end
	end

	assign res.vld             = valid_s1 && emit;
	assign res.data.code_point = cp;
	assign res.data.status     = err ? STATUS_ERR : STATUS_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= ENC_BYTE;
			swap_q   <= 1'b0;
			acc_q    <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			hs_off_q <= '0;
			pend_q   <= 1'b0;
			stop_q   <= 1'b0;
		end else begin
			if (advance) begin
				acc_q    <= acc_n;
				rem_q    <= rem_n;
				len_q    <= len_n;
				hs_off_q <= hs_off_n;
				pend_q   <= pend_n;
				stop_q   <= stop_n;
			end
			// user writes only while idle (not enforced); an encoding change drops partial state
			if (cfg.we) begin
				unique case (cfg.index)
					REG_ENCODING: begin
						enc_q    <= cfg.wdata;
						acc_q    <= '0;
						rem_q    <= '0;
						len_q    <= '0;
						hs_off_q <= '0;
						pend_q   <= 1'b0;
					end
					REG_SWAP_BYTES: begin
						swap_q <= cfg.wdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/core/ucud_out_stage.sv
// Result register of the code unit decoder.
`timescale 1ns / 1ps
module ucud_out_stage import ucud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ucud_res_t res,
	input  logic      advance,
	output logic      can_take,
	output logic      out_valid,
	input  logic      out_ready,
	output ucud_out_t out_data
);

	logic      out_valid_q;
	ucud_out_t out_data_q;

	assign can_take  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.vld;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.vld) begin
			out_data_q <= res.data;
		end
	end

endmodule

// File: rtl/core/ucud_checker.sv
// Port-level checks of the code unit decoder and their binding to the top level.
`timescale 1ns / 1ps
module ucud_checker import ucud_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input ucud_out_t  out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_ERR |-> out_data.code_point == '0)
		else $error("error result with nonzero code point");

	// an empty result register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

endmodule

bind unicode_code_unit_decoder ucud_checker u_ucud_checker (.*);

// File: bench/tb.sv
// Testbench for the code unit decoder: directed and random streams checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import ucud_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 16;

	// Encoding codes that the block treats as errors.
	localparam logic [2:0] ENC_SPARE_LO  = 3'd5;
	localparam logic [2:0] ENC_SPARE_MID = 3'd6;
	localparam logic [2:0] ENC_SPARE_HI  = 3'd7;

	class code_point_scoreboard;
		logic [2:0]  enc_sel = ENC_BYTE;
		logic        swap_on = 1'b0;
		logic [30:0] acc = '0;
		logic [2:0]  left = '0;
		logic [2:0]  seq_len = '0;
		logic [15:0] hi_unit = '0;
		logic        hi_pending = 1'b0;
		logic        halted = 1'b0;
		ucud_out_t   due_points[$];
		int unsigned mismatches = 0;

		function void clear_partial();
			acc = '0;
			left = '0;
			seq_len = '0;
			hi_unit = '0;
			hi_pending = 1'b0;
		endfunction

		function void set_register(logic idx, logic [2:0] val);
			if (idx == REG_ENCODING) begin
				enc_sel = val;
				clear_partial();
			end else begin
				swap_on = val[0];
			end
		endfunction

		function void post(logic [30:0] cp, logic st);
			ucud_out_t r;
			if (st == STATUS_ERR) begin
				halted = 1'b1;
				clear_partial();
				cp = '0;
			end
			r.code_point = cp;
			r.status = st;
			due_points.push_back(r);
		endfunction

		function void take_utf8(logic [7:0] b);
			logic [30:0] v;
			logic [30:0] floor;
			if (left == 0) begin
				if (!b[7]) begin
					post(31'(b), STATUS_OK);
					return;
				end
				casez (b)
					8'b110?????: begin seq_len = 3'd2; acc = 31'(b[4:0]); end
					8'b1110????: begin seq_len = 3'd3; acc = 31'(b[3:0]); end
					8'b11110???: begin seq_len = 3'd4; acc = 31'(b[2:0]); end
					8'b111110??: begin seq_len = 3'd5; acc = 31'(b[1:0]); end
					8'b1111110?: begin seq_len = 3'd6; acc = 31'(b[0]); end
					default: begin
						post('0, STATUS_ERR);
						return;
					end
				endcase
				left = seq_len - 3'd1;
				return;
			end
			if (b[7:6] != 2'b10) begin
				post('0, STATUS_ERR);
				return;
			end
			acc = {acc[24:0], b[5:0]};
			left = left - 3'd1;
			if (left != 0)
				return;
			v = acc;
			case (seq_len)
				3'd2:    floor = 31'h80;
				3'd3:    floor = 31'h800;
				3'd4:    floor = 31'h1_0000;
				3'd5:    floor = 31'h20_0000;
				3'd6:    floor = 31'h400_0000;
				default: floor = '0;
			endcase
			acc = '0;
			seq_len = '0;
			post(v, (v < floor) ? STATUS_ERR : STATUS_OK);
		endfunction

		function void take_utf16(logic [15:0] u);
			logic [31:0] joined;
			if (hi_pending) begin
				// second unit is joined unchecked
				joined = (({16'h0, hi_unit} - 32'hD800) << 10) + {16'h0, u}
					- 32'hDC00 + 32'h1_0000;
				hi_pending = 1'b0;
				hi_unit = '0;
				post(joined[30:0], STATUS_OK);
			end else if (u >= 16'hD800 && u < 16'hE000) begin
				hi_unit = u;
				hi_pending = 1'b1;
			end else begin
				post(31'(u), STATUS_OK);
			end
		endfunction

		function void take_unit(ucud_in_t item);
			logic [15:0] half;
			logic [31:0] word;
			half = item.code_unit[15:0];
			word = item.code_unit;
			if (item.start_of_stream) begin
				halted = 1'b0;
				clear_partial();
			end
			if (halted)
				return;
			if (swap_on) begin
				half = {half[7:0], half[15:8]};
				word = {word[7:0], word[15:8], word[23:16], word[31:24]};
			end
			case (enc_sel)
				ENC_BYTE:  post(31'(item.code_unit[7:0]), STATUS_OK);
				ENC_UCS2:  post(31'(half), STATUS_OK);
				ENC_UCS4:  post(word[30:0], STATUS_OK);
				ENC_UTF8:  take_utf8(item.code_unit[7:0]);
				ENC_UTF16: take_utf16(half);
				default:   post('0, STATUS_ERR);
			endcase
		endfunction

		function void check_code_point(ucud_out_t got);
			ucud_out_t want;
			if (due_points.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected: code_point %h status %0d",
						$realtime, got.code_point, got.status);
				return;
			end
			want = due_points.pop_front();
			if (got.code_point !== want.code_point || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: code_point exp %h got %h, status exp %0d got %0d",
						$realtime, want.code_point, got.code_point, want.status, got.status);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	ucud_in_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	ucud_out_t  out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = REG_ENCODING;
	logic [2:0] cfg_wdata = '0;

	code_point_scoreboard points = new;

	int tx_idle_pct = 13;
	int rx_idle_pct = 81;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;
	int units_sent = 0;
	bit restart = 1'b1;

	unicode_code_unit_decoder dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				points.check_code_point(out_data);
			if (in_valid && in_ready)
				points.take_unit(in_data);
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_taken != holds_asked) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_taken <= holds_taken + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		int stall_run;
		stall_run = 0;
		while (stall_run < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stall_run = 0;
			else
				stall_run++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_unit(logic [31:0] unit, bit sos);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= '{code_unit: unit, start_of_stream: sos};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (points.due_points.size() != 0);
	endtask

	// Let units that give no result leave the pipeline too.
	task automatic quiesce();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [2:0] enc, bit swap);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENCODING;
		cfg_wdata <= enc;
		@(posedge clk);
		cfg_index <= REG_SWAP_BYTES;
		cfg_wdata <= {2'b00, swap};
		@(posedge clk);
		cfg_we <= 1'b0;
		points.set_register(REG_ENCODING, enc);
		points.set_register(REG_SWAP_BYTES, {2'b00, swap});
	endtask

	task automatic send_utf8_char();
		int kind, len, cut, k;
		logic [30:0] lo, hi, v;
		logic [7:0] seq [6];
		bit sos;
		kind = $urandom_range(99);
		len = ($urandom_range(3) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
		case (len)
			1:       begin lo = 31'h0;        hi = 31'h7F;        end
			2:       begin lo = 31'h80;       hi = 31'h7FF;       end
			3:       begin lo = 31'h800;      hi = 31'hFFFF;      end
			4:       begin lo = 31'h1_0000;   hi = 31'h1F_FFFF;   end
			5:       begin lo = 31'h20_0000;  hi = 31'h3FF_FFFF;  end
			default: begin lo = 31'h400_0000; hi = 31'h7FFF_FFFF; end
		endcase
		// overlong: a value that fits a shorter form
		if (kind < 8 && len > 1)
			v = 31'($urandom_range(lo - 1, 0));
		else
			v = 31'($urandom_range(hi, lo));
		if (len == 1)
			seq[0] = v[7:0];
		else
			seq[0] = 8'(8'hFF << (8 - len)) | 8'(v >> (6 * (len - 1)));
		for (k = 1; k < len; k++)
			seq[k] = 8'h80 | 8'(6'(v >> (6 * (len - 1 - k))));
		cut = len;
		if (kind >= 8 && kind < 16 && len > 1) begin
			k = $urandom_range(len - 1, 1);
			seq[k] = $urandom_range(1) ? 8'($urandom_range(8'h7F)) :
				8'($urandom_range(8'hFF, 8'hC0));
			cut = k + 1;
		end else if (kind >= 16 && kind < 22) begin
			case ($urandom_range(2))
				0:       seq[0] = 8'($urandom_range(8'hBF, 8'h80));
				1:       seq[0] = 8'hFE;
				default: seq[0] = 8'hFF;
			endcase
			cut = 1;
		end else if (kind >= 22 && kind < 28 && len > 1) begin
			// truncate; the next character restarts the stream
			cut = $urandom_range(len - 1, 1);
		end else if (kind >= 28 && kind < 32) begin
			seq[0] = 8'($urandom);
			cut = 1;
		end
		sos = restart || ($urandom_range(19) == 0);
		for (k = 0; k < cut; k++)
			send_unit({24'($urandom), seq[k]}, (k == 0) && sos);
		units_sent += cut;
		restart = (kind < 32);
	endtask

	task automatic send_utf16_char(bit swap);
		int kind, n, k;
		logic [15:0] w [2];
		bit sos;
		kind = $urandom_range(99);
		n = 2;
		if (kind < 45) begin
			w[0] = $urandom_range(1) ? 16'($urandom_range(16'hD7FF)) :
				16'($urandom_range(16'hFFFF, 16'hE000));
			n = 1;
		end else if (kind < 88) begin
			w[0] = 16'($urandom_range(16'hDBFF, 16'hD800));
			w[1] = 16'($urandom_range(16'hDFFF, 16'hDC00));
		end else if (kind < 96) begin
			w[0] = 16'($urandom_range(16'hDFFF, 16'hD800));
			w[1] = 16'($urandom);
		end else begin
			// lone surrogate cut off by a start of stream
			w[0] = 16'($urandom_range(16'hDFFF, 16'hD800));
			n = 1;
		end
		sos = restart || ($urandom_range(19) == 0);
		for (k = 0; k < n; k++)
			send_unit({16'($urandom), swap ? {w[k][7:0], w[k][15:8]} : w[k]},
				(k == 0) && sos);
		units_sent += n;
		restart = (kind >= 96);
	endtask

	task automatic directed_checks();
		configure(ENC_BYTE, 1'b0);
		send_unit(32'hFFFF_FF00, 1'b0);
		send_unit(32'h0000_00FF, 1'b0);
		quiesce();
		configure(ENC_UCS2, 1'b1);
		send_unit(32'hABCD_12FF, 1'b0);
		quiesce();
		// swapped into the top byte, then truncated to 31 bits
		configure(ENC_UCS4, 1'b1);
		send_unit(32'h0000_00FF, 1'b0);
		quiesce();
		configure(ENC_UTF8, 1'b0);
		send_unit(32'h0000_00FD, 1'b0);
		repeat (5) send_unit(32'h0000_00BF, 1'b0);
		send_unit(32'h0000_00FF, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
		send_unit(32'h0000_00C1, 1'b1);
		send_unit(32'h0000_00BF, 1'b0);
		send_unit(32'h0000_00E2, 1'b1);
		send_unit(32'h0000_0041, 1'b0);
		send_unit(32'h0000_00E2, 1'b1);
		send_unit(32'h0000_007F, 1'b1);
		send_unit(32'h0000_00E2, 1'b0);
		quiesce();
		// rewriting the encoding drops the open sequence
		configure(ENC_UTF8, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
		quiesce();
		configure(ENC_UTF16, 1'b0);
		send_unit(32'h0000_D83D, 1'b0);
		send_unit(32'h0000_DE00, 1'b0);
		send_unit(32'h0000_DC00, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
		quiesce();
		configure(ENC_SPARE_HI, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
	endtask

	task automatic run_phase(int p);
		logic [2:0] enc;
		bit swap;
		bit paused;
		int target;
		case (p)
			0, 4, 8, 11: enc = ENC_UTF8;
			1, 15:       enc = ENC_BYTE;
			2, 7, 12:    enc = ENC_UTF16;
			3, 9:        enc = ENC_UCS4;
			5:           enc = ENC_SPARE_LO;
			6, 13:       enc = ENC_UCS2;
			10:          enc = ENC_SPARE_HI;
			default:     enc = ENC_SPARE_MID;
		endcase
		swap = 1'($urandom_range(1));
		paused = 1'b0;
		target = (enc > ENC_UTF16) ? 20 : 65;
		quiesce();
		tx_idle_pct = (p < 5) ? 13 : (p < 11) ? 81 : 0;
		rx_idle_pct = (p < 5) ? 81 : (p < 11) ? 13 : 0;
		configure(enc, swap);
		// hold the receiver while units keep coming, to back up the pipeline
		if (p == 3 || p == 12)
			holds_asked <= holds_asked + 1;
		units_sent = 0;
		restart = 1'b1;
		while (units_sent < target) begin
			if (p == 9 && !paused && units_sent >= target / 2) begin
				wait_results();
				paused = 1'b1;
			end
			case (enc)
				ENC_UTF8:  send_utf8_char();
				ENC_UTF16: send_utf16_char(swap);
				ENC_BYTE, ENC_UCS2, ENC_UCS4: begin
					send_unit($urandom, restart || ($urandom_range(15) == 0));
					restart = 1'b0;
					units_sent++;
				end
				default: begin
					send_unit($urandom, restart || ($urandom_range(1) == 0));
					restart = 1'b0;
					units_sent++;
				end
			endcase
		end
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		for (p = 0; p < PHASES; p++)
			run_phase(p);
		quiesce();
		if (points.mismatches == 0 && points.due_points.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
